FILE: sv/bmt_pkg.sv
// Shared types, constants and helpers for the bracket markup tokenizer.
`timescale 1ns / 1ps

package bmt_pkg;

   // Default offset width and the fixed width of offsets on the result port
   localparam int POS_WIDTH_DEFAULT = 16;
   localparam int OUT_POS_WIDTH     = 16;

   // Queue depths (powers of two, pointers wrap by overflow)
   localparam int MID_DEPTH = 2;
   localparam int RSP_DEPTH = 4;

   // Markup characters
   localparam logic [7:0] CHAR_NUL   = 8'h00;
   localparam logic [7:0] CHAR_OPEN  = 8'h5B;
   localparam logic [7:0] CHAR_CLOSE = 8'h5D;
   localparam logic [7:0] CHAR_BANG  = 8'h21;
   localparam logic [7:0] CHAR_SPACE = 8'h20;

   typedef enum logic [2:0] {
      TK_TEXT     = 3'd0,
      TK_ATTR     = 3'd1,
      TK_END_ATTR = 3'd2,
      TK_ESCAPE   = 3'd3,
      TK_ERROR    = 3'd4
   } token_kind_type;

   typedef enum logic [1:0] {
      ERR_NONE         = 2'd0,
      ERR_EMPTY        = 2'd1,
      ERR_UNTERMINATED = 2'd2,
      ERR_TOO_LONG     = 2'd3
   } error_code_type;

   typedef enum logic [1:0] {
      MODE_IDLE    = 2'd0,
      MODE_TEXT    = 2'd1,
      MODE_BRACKET = 2'd2,
      MODE_DROP    = 2'd3
   } scan_mode_type;

   typedef logic [OUT_POS_WIDTH-1:0] out_pos_type;

   typedef struct packed {
      logic [7:0] char_byte;
      logic       is_last;
   } req_type;

   typedef struct packed {
      token_kind_type token_kind;
      out_pos_type    start_pos;
      out_pos_type    end_pos;
      error_code_type error_code;
      logic           end_of_run;
   } rsp_type;

   // Byte class decoded by the front end
   typedef struct packed {
      logic is_zero;
      logic ends;
      logic is_open;
      logic is_close;
      logic is_bang;
      logic is_space;
      logic too_long;
   } class_type;

   // Build one token with end_of_run clear
   function automatic rsp_type make_rsp(token_kind_type kind, out_pos_type s_pos,
                                        out_pos_type e_pos, error_code_type code);
      rsp_type r;
      r.token_kind = kind;
      r.start_pos  = s_pos;
      r.end_pos    = e_pos;
      r.error_code = code;
      r.end_of_run = 1'b0;
      return r;
   endfunction

endpackage

FILE: sv/bmt_front.sv
// Front end: byte offset counter, byte classification and the queue to the back end.
`timescale 1ns / 1ps

module bmt_front #(
   parameter int POS_WIDTH = bmt_pkg::POS_WIDTH_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  bmt_pkg::req_type     req_data,
   output logic                 full,
   output logic                 item_valid,
   output bmt_pkg::class_type   item_class,
   output logic [POS_WIDTH:0]   item_pos,
   input  logic                 item_take
);

   localparam int PP    = POS_WIDTH + 1;
   localparam int PTR_W = $clog2(bmt_pkg::MID_DEPTH);
   localparam int CNT_W = $clog2(bmt_pkg::MID_DEPTH + 1);

   logic                 accept;
   bmt_pkg::class_type   cls;
   logic [PP-1:0]        pos_ff, pos_in;
   logic [PTR_W-1:0]     wptr_ff, wptr_in, rptr_ff, rptr_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   bmt_pkg::class_type   cls_mem_ff [bmt_pkg::MID_DEPTH];
   logic [PP-1:0]        pos_mem_ff [bmt_pkg::MID_DEPTH];

   assign full   = (count_ff == CNT_W'(bmt_pkg::MID_DEPTH));
   assign accept = push & ~full;

   // Classify the incoming byte
   always_comb begin
      cls.is_zero  = (req_data.char_byte == bmt_pkg::CHAR_NUL);
      cls.ends     = req_data.is_last | cls.is_zero;
      cls.is_open  = (req_data.char_byte == bmt_pkg::CHAR_OPEN);
      cls.is_close = (req_data.char_byte == bmt_pkg::CHAR_CLOSE);
      cls.is_bang  = (req_data.char_byte == bmt_pkg::CHAR_BANG);
      cls.is_space = (req_data.char_byte == bmt_pkg::CHAR_SPACE);
      cls.too_long = pos_ff[POS_WIDTH];
   end

   // Advance the offset, saturating one past the range; restart at string end
   always_comb begin
      pos_in = pos_ff;
      if (accept) begin
         if (cls.ends) begin
            pos_in = '0;
         end else if (!pos_ff[POS_WIDTH]) begin
            pos_in = pos_ff + PP'(1);
         end
      end
   end

   // Queue pointers
   always_comb begin
      wptr_in  = wptr_ff + PTR_W'(accept);
      rptr_in  = rptr_ff + PTR_W'(item_take);
      count_in = count_ff + CNT_W'(accept) - CNT_W'(item_take);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff   <= '0;
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         pos_ff   <= pos_in;
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
   end

   // Store the classified byte
   always_ff @(posedge clock) begin
      if (accept) begin
         cls_mem_ff[wptr_ff] <= cls;
         pos_mem_ff[wptr_ff] <= pos_ff;
      end
   end

   assign item_valid = (count_ff != '0);
   assign item_class = cls_mem_ff[rptr_ff];
   assign item_pos   = pos_mem_ff[rptr_ff];

endmodule

FILE: sv/bmt_back.sv
// Back end: scan mode, bracket trimming marks and token generation, up to two tokens a byte.
`timescale 1ns / 1ps

module bmt_back #(
   parameter int POS_WIDTH = bmt_pkg::POS_WIDTH_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 item_valid,
   input  bmt_pkg::class_type   item_class,
   input  logic [POS_WIDTH:0]   item_pos,
   output logic                 item_take,
   input  logic                 rsp_space,
   output logic                 rsp_wr0,
   output logic                 rsp_wr1,
   output bmt_pkg::rsp_type     rsp_data0,
   output bmt_pkg::rsp_type     rsp_data1
);

   localparam int PP = POS_WIDTH + 1;

   bmt_pkg::scan_mode_type    mode_ff, mode_mid, mode_in;
   logic [POS_WIDTH-1:0]      ts_ff, ts_in;
   logic                      fn_v_ff, fn_v_in, fb_v_ff, fb_v_in;
   logic                      ln_v_ff, ln_v_in, pn_v_ff, pn_v_in;
   logic [POS_WIDTH-1:0]      fn_pos_ff, fn_pos_in, fb_pos_ff, fb_pos_in;
   logic [POS_WIDTH-1:0]      ln_pos_ff, ln_pos_in, pn_pos_ff, pn_pos_in;
   logic                      bang_first_ff, bang_first_in, bang_last_ff, bang_last_in;

   logic                      active, long_err, first_content;
   logic                      do_open, do_text, do_content;
   logic [PP-1:0]             p_prev;
   logic                      close_ok;
   bmt_pkg::token_kind_type   close_kind;
   logic [PP-1:0]             close_s, close_e;
   logic                      a_v, b_v;
   bmt_pkg::rsp_type          a_rsp, b_rsp;

   assign item_take     = item_valid & rsp_space;
   assign active        = (mode_ff != bmt_pkg::MODE_DROP);
   assign long_err      = ~item_class.is_zero & item_class.too_long;
   assign p_prev        = item_pos - PP'(1);
   assign first_content = (item_pos == ({1'b0, ts_ff} + PP'(1)));

   assign do_open    = active & ~long_err & item_class.is_open &
                       ((mode_ff == bmt_pkg::MODE_IDLE) || (mode_ff == bmt_pkg::MODE_TEXT));
   assign do_text    = active & ~long_err & (mode_ff == bmt_pkg::MODE_IDLE) &
                       ~item_class.is_zero & ~item_class.is_open;
   assign do_content = active & ~long_err & (mode_ff == bmt_pkg::MODE_BRACKET) &
                       ~item_class.is_zero & ~item_class.is_close;

   // Decide the token a closing bracket yields
   always_comb begin
      if (bang_last_ff) begin
         close_ok   = pn_v_ff;
         close_kind = bmt_pkg::TK_ESCAPE;
         close_s    = {1'b0, fn_pos_ff};
         close_e    = {1'b0, pn_pos_ff};
      end else if (bang_first_ff) begin
         close_ok   = fb_v_ff;
         close_kind = bmt_pkg::TK_END_ATTR;
         close_s    = {1'b0, fb_pos_ff};
         close_e    = {1'b0, ln_pos_ff};
      end else begin
         close_ok   = fn_v_ff;
         close_kind = bmt_pkg::TK_ATTR;
         close_s    = {1'b0, fn_pos_ff};
         close_e    = p_prev;
      end
   end

   // Next scan mode; mode_mid is the mode before a string end is applied
   always_comb begin
      mode_mid = mode_ff;
      if (active && long_err) begin
         mode_mid = bmt_pkg::MODE_DROP;
      end else begin
         case (mode_ff)
            bmt_pkg::MODE_IDLE: begin
               if (item_class.is_open) begin
                  mode_mid = bmt_pkg::MODE_BRACKET;
               end else if (!item_class.is_zero) begin
                  mode_mid = bmt_pkg::MODE_TEXT;
               end
            end
            bmt_pkg::MODE_TEXT: begin
               if (item_class.is_zero) begin
                  mode_mid = bmt_pkg::MODE_IDLE;
               end else if (item_class.is_open) begin
                  mode_mid = bmt_pkg::MODE_BRACKET;
               end
            end
            bmt_pkg::MODE_BRACKET: begin
               if (item_class.is_zero) begin
                  mode_mid = bmt_pkg::MODE_DROP;
               end else if (item_class.is_close) begin
                  mode_mid = close_ok ? bmt_pkg::MODE_IDLE : bmt_pkg::MODE_DROP;
               end
            end
            default: begin
               mode_mid = mode_ff;
            end
         endcase
      end
      mode_in = item_class.ends ? bmt_pkg::MODE_IDLE : mode_mid;
   end

   // Update token start and trimming marks
   always_comb begin
      ts_in         = ts_ff;
      fn_v_in       = fn_v_ff;
      fn_pos_in     = fn_pos_ff;
      fb_v_in       = fb_v_ff;
      fb_pos_in     = fb_pos_ff;
      ln_v_in       = ln_v_ff;
      ln_pos_in     = ln_pos_ff;
      pn_v_in       = pn_v_ff;
      pn_pos_in     = pn_pos_ff;
      bang_first_in = bang_first_ff;
      bang_last_in  = bang_last_ff;
      if (do_open) begin
         ts_in         = item_pos[POS_WIDTH-1:0];
         fn_v_in       = 1'b0;
         fb_v_in       = 1'b0;
         ln_v_in       = 1'b0;
         pn_v_in       = 1'b0;
         bang_first_in = 1'b0;
         bang_last_in  = 1'b0;
      end else if (do_text) begin
         ts_in = item_pos[POS_WIDTH-1:0];
      end else if (do_content) begin
         if (first_content) begin
            bang_first_in = item_class.is_bang;
         end
         bang_last_in = item_class.is_bang;
         if (!item_class.is_space) begin
            if (!fn_v_ff) begin
               fn_v_in   = 1'b1;
               fn_pos_in = item_pos[POS_WIDTH-1:0];
            end
            if (!first_content && !fb_v_ff) begin
               fb_v_in   = 1'b1;
               fb_pos_in = item_pos[POS_WIDTH-1:0];
            end
            pn_v_in   = ln_v_ff;
            pn_pos_in = ln_pos_ff;
            ln_v_in   = 1'b1;
            ln_pos_in = item_pos[POS_WIDTH-1:0];
         end
      end
   end

   // Tokens: one from the byte itself, one from the string ending on it
   always_comb begin
      a_v   = 1'b0;
      a_rsp = bmt_pkg::make_rsp(bmt_pkg::TK_TEXT, '0, '0, bmt_pkg::ERR_NONE);
      b_v   = 1'b0;
      b_rsp = bmt_pkg::make_rsp(bmt_pkg::TK_TEXT, '0, '0, bmt_pkg::ERR_NONE);
      if (active) begin
         if (long_err) begin
            a_v   = 1'b1;
            a_rsp = bmt_pkg::make_rsp(bmt_pkg::TK_ERROR, '0, '1, bmt_pkg::ERR_TOO_LONG);
         end else if ((mode_ff == bmt_pkg::MODE_TEXT) &&
                      (item_class.is_zero || item_class.is_open)) begin
            a_v   = 1'b1;
            a_rsp = bmt_pkg::make_rsp(bmt_pkg::TK_TEXT, bmt_pkg::out_pos_type'(ts_ff),
                                      bmt_pkg::out_pos_type'(p_prev), bmt_pkg::ERR_NONE);
         end else if ((mode_ff == bmt_pkg::MODE_BRACKET) && item_class.is_zero) begin
            a_v   = 1'b1;
            a_rsp = bmt_pkg::make_rsp(bmt_pkg::TK_ERROR, bmt_pkg::out_pos_type'(ts_ff),
                                      bmt_pkg::out_pos_type'(item_pos),
                                      bmt_pkg::ERR_UNTERMINATED);
         end else if ((mode_ff == bmt_pkg::MODE_BRACKET) && item_class.is_close) begin
            a_v = 1'b1;
            if (close_ok) begin
               a_rsp = bmt_pkg::make_rsp(close_kind, bmt_pkg::out_pos_type'(close_s),
                                         bmt_pkg::out_pos_type'(close_e), bmt_pkg::ERR_NONE);
            end else begin
               a_rsp = bmt_pkg::make_rsp(bmt_pkg::TK_ERROR, bmt_pkg::out_pos_type'(ts_ff),
                                         bmt_pkg::out_pos_type'(item_pos),
                                         bmt_pkg::ERR_EMPTY);
            end
         end
         if (item_class.ends && (mode_mid == bmt_pkg::MODE_TEXT)) begin
            b_v   = 1'b1;
            b_rsp = bmt_pkg::make_rsp(bmt_pkg::TK_TEXT, bmt_pkg::out_pos_type'(ts_in),
                                      bmt_pkg::out_pos_type'(item_pos), bmt_pkg::ERR_NONE);
         end else if (item_class.ends && (mode_mid == bmt_pkg::MODE_BRACKET)) begin
            b_v   = 1'b1;
            b_rsp = bmt_pkg::make_rsp(bmt_pkg::TK_ERROR, bmt_pkg::out_pos_type'(ts_in),
                                      bmt_pkg::out_pos_type'(item_pos),
                                      bmt_pkg::ERR_UNTERMINATED);
         end
      end
   end

   // Pack the tokens into the two queue write slots
   always_comb begin
      rsp_wr0   = item_take & (a_v | b_v);
      rsp_wr1   = item_take & a_v & b_v;
      rsp_data0 = a_v ? a_rsp : b_rsp;
      rsp_data0.end_of_run = ~(a_v & b_v);
      rsp_data1 = b_rsp;
      rsp_data1.end_of_run = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff       <= bmt_pkg::MODE_IDLE;
         ts_ff         <= '0;
         fn_v_ff       <= 1'b0;
         fb_v_ff       <= 1'b0;
         ln_v_ff       <= 1'b0;
         pn_v_ff       <= 1'b0;
         bang_first_ff <= 1'b0;
         bang_last_ff  <= 1'b0;
      end else if (item_take) begin
         mode_ff       <= mode_in;
         ts_ff         <= ts_in;
         fn_v_ff       <= fn_v_in;
         fb_v_ff       <= fb_v_in;
         ln_v_ff       <= ln_v_in;
         pn_v_ff       <= pn_v_in;
         bang_first_ff <= bang_first_in;
         bang_last_ff  <= bang_last_in;
      end
   end

   // Mark offsets hold no meaning while their valid bit is clear
   always_ff @(posedge clock) begin
      if (item_take) begin
         fn_pos_ff <= fn_pos_in;
         fb_pos_ff <= fb_pos_in;
         ln_pos_ff <= ln_pos_in;
         pn_pos_ff <= pn_pos_in;
      end
   end

endmodule

FILE: sv/bmt_rsp_queue.sv
// Token queue: two writes and one read per cycle.
`timescale 1ns / 1ps

module bmt_rsp_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               wr0,
   input  logic               wr1,
   input  bmt_pkg::rsp_type   data0,
   input  bmt_pkg::rsp_type   data1,
   output logic               space,
   input  logic               pop,
   output logic               empty,
   output bmt_pkg::rsp_type   rsp_data
);

   localparam int PTR_W = $clog2(bmt_pkg::RSP_DEPTH);
   localparam int CNT_W = $clog2(bmt_pkg::RSP_DEPTH + 1);

   logic                 rd;
   logic [PTR_W-1:0]     wptr_ff, wptr_in, wptr_nx, rptr_ff, rptr_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   bmt_pkg::rsp_type     mem_ff [bmt_pkg::RSP_DEPTH];

   assign empty = (count_ff == '0);
   assign space = (count_ff <= CNT_W'(bmt_pkg::RSP_DEPTH - 2));
   assign rd    = pop & ~empty;

   // Advance pointers and fill count
   always_comb begin
      wptr_nx  = wptr_ff + PTR_W'(1);
      wptr_in  = wptr_ff + PTR_W'(wr0) + PTR_W'(wr1);
      rptr_in  = rptr_ff + PTR_W'(rd);
      count_in = count_ff + CNT_W'(wr0) + CNT_W'(wr1) - CNT_W'(rd);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
   end

   // Store tokens in order
   always_ff @(posedge clock) begin
      if (wr0) begin
         mem_ff[wptr_ff] <= data0;
      end
      if (wr1) begin
         mem_ff[wptr_nx] <= data1;
      end
   end

   assign rsp_data = mem_ff[rptr_ff];

endmodule

FILE: sv/bracket_markup_tokenizer.sv
// Top level of the bracket markup tokenizer.
`timescale 1ns / 1ps

// Takes a markup string one byte per request and returns text, attribute, end
// attribute, escape and error tokens as first and last byte offsets. It takes
// one byte per clock: the front end counts offsets and classifies each byte into
// a two-entry queue, and the back end decodes one queued byte per clock, writing
// zero, one or two tokens into a four-entry token queue. The back end pauses
// while that queue has fewer than two free entries, so the sustained rate is one
// byte per clock as long as tokens are popped as fast as they appear. A token
// reaches the result ports once its byte has passed through the front end queue
// and the back end has written the token into the token queue.
// After an error, bytes are dropped up to and including the string's last byte.
module bracket_markup_tokenizer #(
   parameter int POS_WIDTH = bmt_pkg::POS_WIDTH_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  bmt_pkg::req_type   req_data,
   output logic               full,
   output logic               empty,
   input  logic               pop,
   output bmt_pkg::rsp_type   rsp_data
);

   logic                 item_valid, item_take;
   bmt_pkg::class_type   item_class;
   logic [POS_WIDTH:0]   item_pos;
   logic                 rsp_space, rsp_wr0, rsp_wr1;
   bmt_pkg::rsp_type     rsp_data0, rsp_data1;

   bmt_front #(.POS_WIDTH(POS_WIDTH)) u_front (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .req_data   (req_data),
      .full       (full),
      .item_valid (item_valid),
      .item_class (item_class),
      .item_pos   (item_pos),
      .item_take  (item_take)
   );

   bmt_back #(.POS_WIDTH(POS_WIDTH)) u_back (
      .clock      (clock),
      .reset      (reset),
      .item_valid (item_valid),
      .item_class (item_class),
      .item_pos   (item_pos),
      .item_take  (item_take),
      .rsp_space  (rsp_space),
      .rsp_wr0    (rsp_wr0),
      .rsp_wr1    (rsp_wr1),
      .rsp_data0  (rsp_data0),
      .rsp_data1  (rsp_data1)
   );

   bmt_rsp_queue u_rsp_queue (
      .clock    (clock),
      .reset    (reset),
      .wr0      (rsp_wr0),
      .wr1      (rsp_wr1),
      .data0    (rsp_data0),
      .data1    (rsp_data1),
      .space    (rsp_space),
      .pop      (pop),
      .empty    (empty),
      .rsp_data (rsp_data)
   );

`ifndef NO_ASSERTIONS
   // The token queue comes out of reset empty and the front queue not full
   a_reset_empty: assert property (@(posedge clock) reset |=> (empty && !full))
      else $error("queues not empty after reset");

   // A second token in a cycle always has a first one ahead of it
   a_slot_order: assert property (@(posedge clock) disable iff (reset)
      rsp_wr1 |-> rsp_wr0)
      else $error("second token slot written alone");

   // An error code rides on error tokens only
   a_error_code: assert property (@(posedge clock) disable iff (reset)
      !empty |-> ((rsp_data.token_kind == bmt_pkg::TK_ERROR) ==
                  (rsp_data.error_code != bmt_pkg::ERR_NONE)))
      else $error("error code does not match token kind");

   // Tokens are written only when the queue has room for two
   a_room: assert property (@(posedge clock) disable iff (reset)
      rsp_wr0 |-> rsp_space)
      else $error("token written without room");
`endif

endmodule
